// ===== rtl/nafmt_pkg.sv =====
`default_nettype none

package nafmt_pkg;

   // Depth of the command queue between the front and back parts.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Magnitudes stay below 2^17 (largest is 65535), and at most five digits.
   localparam int unsigned MAG_W = 17;
   localparam int unsigned POS_W = 3;

   // Output format selected by the action field.
   typedef enum logic [1:0] {
      MODE_DEC = 2'd0,
      MODE_HEX = 2'd1,
      MODE_FIX = 2'd2,
      MODE_CHR = 2'd3
   } mode_type;

   // ASCII codes used by the formatter.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   // One classified request as it waits in the queue.
   typedef struct packed {
      mode_type         mode;
      logic             neg;
      logic [MAG_W-1:0] mag;
      logic [POS_W-1:0] top;
      logic [3:0]       tens;
      logic [3:0]       ones;
   } cmd_type;

   // Digit times the power of ten of a decimal position.
   function automatic logic [MAG_W-1:0] dec_mult(input logic [POS_W-1:0] pos,
                                                 input logic [3:0] digit);
      logic [MAG_W-1:0] pow;
      unique case (pos)
         3'd0:    pow = 17'd1;
         3'd1:    pow = 17'd10;
         3'd2:    pow = 17'd100;
         3'd3:    pow = 17'd1000;
         3'd4:    pow = 17'd10000;
         default: pow = 17'd0;
      endcase
      return MAG_W'(pow * digit);
   endfunction

   // ASCII character of one hexadecimal digit, uppercase.
   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      logic [7:0] code;
      if (nibble <= 4'd9) begin
         code = CHAR_ZERO + {4'b0000, nibble};
      end else begin
         code = CHAR_UPPER_A + {4'b0000, nibble} - 8'd10;
      end
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/nafmt_front.sv =====
`default_nettype none

module nafmt_front (
   input  wire logic        [1:0]  req_action,
   input  wire logic signed [15:0] req_int_value,
   input  wire logic signed [31:0] req_fixed_value,
   input  wire logic        [7:0]  req_char_byte,
   input  wire logic               req_push,
   input  wire logic               q_full,
   output      logic               q_push,
   output      nafmt_pkg::cmd_type q_data
);

   logic [15:0]                   iv;
   logic [31:0]                   fix_mag;
   logic [23:0]                   frac_prod;
   logic [6:0]                    frac_round;
   logic [16:0]                   whole_val;
   logic [6:0]                    frac_val;
   logic [14:0]                   tens_prod;
   logic [3:0]                    tens;
   logic [nafmt_pkg::MAG_W-1:0]   dec_mag;
   logic [nafmt_pkg::POS_W-1:0]   dec_top;
   logic [nafmt_pkg::POS_W-1:0]   hex_top;

   assign iv     = req_int_value;
   assign q_push = req_push && !q_full;

   // Fixed-point magnitude, rounded two-digit fraction and carry into the integer part.
   always_comb begin
      fix_mag    = req_fixed_value[31] ? (32'd0 - req_fixed_value) : req_fixed_value;
      frac_prod  = {8'd0, fix_mag[15:0]} * 24'd100 + 24'd32768;
      frac_round = frac_prod[22:16];
      if (frac_round == 7'd100) begin
         frac_val  = 7'd0;
         whole_val = {1'b0, fix_mag[31:16]} + 17'd1;
      end else begin
         frac_val  = frac_round;
         whole_val = {1'b0, fix_mag[31:16]};
      end
      // Divide by ten through the reciprocal 205 / 2048, exact for every 7-bit fraction value.
      tens_prod = {8'd0, frac_val} * 15'd205;
      tens      = tens_prod[14:11];
   end

   // Value that the back part prints: decimal magnitude, raw hexadecimal value or character byte.
   always_comb begin
      unique case (nafmt_pkg::mode_type'(req_action))
         nafmt_pkg::MODE_DEC:
            dec_mag = iv[15] ? (17'h10000 - {1'b0, iv}) : {1'b0, iv};
         nafmt_pkg::MODE_FIX:
            dec_mag = whole_val;
         nafmt_pkg::MODE_HEX:
            dec_mag = {1'b0, iv};
         nafmt_pkg::MODE_CHR:
            dec_mag = {9'd0, req_char_byte};
      endcase
   end

   // Position of the leading decimal digit.
   always_comb begin
      priority if (dec_mag >= 17'd10000) begin
         dec_top = 3'd4;
      end else if (dec_mag >= 17'd1000) begin
         dec_top = 3'd3;
      end else if (dec_mag >= 17'd100) begin
         dec_top = 3'd2;
      end else if (dec_mag >= 17'd10) begin
         dec_top = 3'd1;
      end else begin
         dec_top = 3'd0;
      end
   end

   // Position of the leading nonzero hexadecimal digit, or of the lowest one when the value is zero.
   always_comb begin
      priority if (iv[15:12] != 4'd0) begin
         hex_top = 3'd3;
      end else if (iv[11:8] != 4'd0) begin
         hex_top = 3'd2;
      end else if (iv[7:4] != 4'd0) begin
         hex_top = 3'd1;
      end else begin
         hex_top = 3'd0;
      end
   end

   // Build the command for the back part.
   always_comb begin
      q_data.mode = nafmt_pkg::mode_type'(req_action);
      q_data.mag  = dec_mag;
      q_data.tens = tens;
      q_data.ones = 4'(frac_val - {3'd0, tens} * 7'd10);
      unique case (nafmt_pkg::mode_type'(req_action))
         nafmt_pkg::MODE_DEC: begin
            q_data.neg = iv[15];
            q_data.top = dec_top;
         end
         nafmt_pkg::MODE_FIX: begin
            q_data.neg = req_fixed_value[31];
            q_data.top = dec_top;
         end
         nafmt_pkg::MODE_HEX: begin
            q_data.neg = 1'b0;
            q_data.top = hex_top;
         end
         nafmt_pkg::MODE_CHR: begin
            q_data.neg = 1'b0;
            q_data.top = 3'd0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/nafmt_queue.sv =====
`default_nettype none

module nafmt_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire nafmt_pkg::cmd_type push_data,
   output      logic               full,
   input  wire logic               pop,
   output      nafmt_pkg::cmd_type pop_data,
   output      logic               empty
);

   localparam int unsigned PTR_W = nafmt_pkg::QUEUE_PTR_W;
   localparam int unsigned CNT_W = nafmt_pkg::QUEUE_CNT_W;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(nafmt_pkg::QUEUE_DEPTH - 1);

   nafmt_pkg::cmd_type entries_ff [nafmt_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(nafmt_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/nafmt_back.sv =====
`default_nettype none

module nafmt_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_empty,
   input  wire nafmt_pkg::cmd_type q_data,
   output      logic               q_pop,
   output      logic        [7:0]  rsp_char_code,
   output      logic               rsp_last,
   output      logic               rsp_empty,
   input  wire logic               rsp_pop
);

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_SIGN  = 11'b000_0000_0010,
      ST_PRE0  = 11'b000_0000_0100,
      ST_PREX  = 11'b000_0000_1000,
      ST_DIGIT = 11'b000_0001_0000,
      ST_DOT   = 11'b000_0010_0000,
      ST_TENS  = 11'b000_0100_0000,
      ST_ONES  = 11'b000_1000_0000,
      ST_NL    = 11'b001_0000_0000,
      ST_CR    = 11'b010_0000_0000,
      ST_CHAR  = 11'b100_0000_0000
   } state_type;

   state_type                      state_ff, state_in;
   nafmt_pkg::cmd_type             cmd_ff, cmd_in;
   logic [nafmt_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic                           out_valid_ff, out_valid_in;
   logic [7:0]                     char_ff, char_in;
   logic                           last_ff, last_in;
   logic                           advance;
   logic [3:0]                     dec_digit;
   logic [nafmt_pkg::MAG_W-1:0]    dec_rest;
   logic [3:0]                     nibble;
   state_type                      first_state;

   assign rsp_empty     = !out_valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;
   assign advance       = !out_valid_ff || rsp_pop;

   // Decimal digit at the current position and the remainder below it.
   always_comb begin
      dec_digit = 4'd0;
      for (int j = 1; j <= 9; j++) begin
         if (cmd_ff.mag >= nafmt_pkg::dec_mult(pos_ff, 4'(j))) begin
            dec_digit = 4'(j);
         end
      end
      dec_rest = cmd_ff.mag - nafmt_pkg::dec_mult(pos_ff, dec_digit);
   end

   // Hexadecimal digit at the current position.
   always_comb begin
      unique case (pos_ff[1:0])
         2'd0: nibble = cmd_ff.mag[3:0];
         2'd1: nibble = cmd_ff.mag[7:4];
         2'd2: nibble = cmd_ff.mag[11:8];
         2'd3: nibble = cmd_ff.mag[15:12];
      endcase
   end

   // First character of a newly loaded request.
   always_comb begin
      unique case (q_data.mode)
         nafmt_pkg::MODE_DEC,
         nafmt_pkg::MODE_FIX: first_state = q_data.neg ? ST_SIGN : ST_DIGIT;
         nafmt_pkg::MODE_HEX: first_state = ST_PRE0;
         nafmt_pkg::MODE_CHR: first_state = ST_CHAR;
      endcase
   end

   // Sequencer: one character into the output register per step.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      char_in      = char_ff;
      last_in      = last_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_data;
               pos_in   = q_data.top;
               state_in = first_state;
            end
         end
         ST_SIGN: begin
            if (advance) begin
               out_valid_in = 1'b1;
               char_in      = nafmt_pkg::CHAR_MINUS;
               last_in      = 1'b0;
               state_in     = ST_DIGIT;
            end
         end
         ST_PRE0: begin
            if (advance) begin
               out_valid_in = 1'b1;
               char_in      = nafmt_pkg::CHAR_ZERO;
               last_in      = 1'b0;
               state_in     = ST_PREX;
            end
         end
         ST_PREX: begin
            if (advance) begin
               out_valid_in = 1'b1;
               char_in      = nafmt_pkg::CHAR_X;
               last_in      = 1'b0;
               state_in     = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (advance) begin
               out_valid_in = 1'b1;
               last_in      = 1'b0;
               if (cmd_ff.mode == nafmt_pkg::MODE_HEX) begin
                  char_in = nafmt_pkg::hex_char(nibble);
               end else begin
                  char_in    = nafmt_pkg::CHAR_ZERO + {4'b0000, dec_digit};
                  cmd_in.mag = dec_rest;
               end
               if (pos_ff == '0) begin
                  if (cmd_ff.mode == nafmt_pkg::MODE_HEX) begin
                     last_in  = 1'b1;
                     state_in = ST_IDLE;
                  end else if (cmd_ff.mode == nafmt_pkg::MODE_FIX) begin
                     state_in = ST_DOT;
                  end else begin
                     state_in = ST_NL;
                  end
               end else begin
                  pos_in = pos_ff - 1'b1;
               end
            end
         end
         ST_DOT: begin
            if (advance) begin
               out_valid_in = 1'b1;
               char_in      = nafmt_pkg::CHAR_DOT;
               last_in      = 1'b0;
               state_in     = ST_TENS;
            end
         end
         ST_TENS: begin
            if (advance) begin
               out_valid_in = 1'b1;
               char_in      = nafmt_pkg::CHAR_ZERO + {4'b0000, cmd_ff.tens};
               last_in      = 1'b0;
               state_in     = ST_ONES;
            end
         end
         ST_ONES: begin
            if (advance) begin
               out_valid_in = 1'b1;
               char_in      = nafmt_pkg::CHAR_ZERO + {4'b0000, cmd_ff.ones};
               last_in      = 1'b0;
               state_in     = ST_NL;
            end
         end
         ST_NL: begin
            if (advance) begin
               out_valid_in = 1'b1;
               char_in      = nafmt_pkg::CHAR_NL;
               last_in      = 1'b0;
               state_in     = ST_CR;
            end
         end
         ST_CR: begin
            if (advance) begin
               out_valid_in = 1'b1;
               char_in      = nafmt_pkg::CHAR_CR;
               last_in      = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_CHAR: begin
            if (advance) begin
               out_valid_in = 1'b1;
               char_in      = cmd_ff.mag[7:0];
               last_in      = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Working and output data.
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      pos_ff  <= pos_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

endmodule

`default_nettype wire

// ===== rtl/number_to_ascii_formatter.sv =====
`default_nettype none

// Channel   | Direction | Handshake      | Payload
// request   | in        | req_push/full  | action, int_value, fixed_value, char_byte
// response  | out       | rsp_pop/empty  | char_code, last
//
// Each request is loaded by the back sequencer from its idle state, then printed one
// character per sequencer step; the text is at most 11 characters long.
// The front classifies a request in the cycle it is pushed and parks it in a
// two-entry queue, so requests are taken while the back part is still printing.
// Reset is synchronous and empties the queue, sequencer and output register.
// A stalled response holds the sequencer; the queue then fills and raises full.

module number_to_ascii_formatter (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic        [1:0]  req_action,
   input  wire logic signed [15:0] req_int_value,
   input  wire logic signed [31:0] req_fixed_value,
   input  wire logic        [7:0]  req_char_byte,
   input  wire logic               req_push,
   output      logic               req_full,
   output      logic        [7:0]  rsp_char_code,
   output      logic               rsp_last,
   output      logic               rsp_empty,
   input  wire logic               rsp_pop
);

   nafmt_pkg::cmd_type push_data;
   nafmt_pkg::cmd_type pop_data;
   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_empty;

   assign req_full = q_full;

   // Classify requests.
   nafmt_front u_front (
      .req_action      (req_action),
      .req_int_value   (req_int_value),
      .req_fixed_value (req_fixed_value),
      .req_char_byte   (req_char_byte),
      .req_push        (req_push),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_data          (push_data)
   );

   // Command queue between the two parts.
   nafmt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   // Print characters.
   nafmt_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_data        (pop_data),
      .q_pop         (q_pop),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop)
   );

endmodule

`default_nettype wire
